// File: hdl/kpid_pkg.sv
// Package for the keypad ID entry controller.
// Holds the mode, command and status codes, key codes and derived widths.
// No dependencies.
`default_nettype none

package kpid_pkg;

  // Number of digits that make a complete ID.
  localparam int unsigned IdDigits = 3;
  // Width of the digit counter, wide enough to hold IdDigits itself.
  localparam int unsigned DcntW = $clog2(IdDigits + 1);
  // Width of an index into the digit buffer.
  localparam int unsigned IdxW = (IdDigits > 1) ? $clog2(IdDigits) : 1;

  localparam int unsigned TimeoutW = 8;
  localparam int unsigned RetryW = 4;
  localparam int unsigned IdW = 10;
  localparam logic [IdW-1:0] IdMax = '1;
  localparam logic [TimeoutW-1:0] TimeoutReset = 8'd30;
  localparam logic [RetryW-1:0] RetryReset = 4'd3;

  // Packed widths of the stream payloads.
  localparam int unsigned InDataW = 8;
  localparam int unsigned OutDataW = 24;

  typedef enum logic [1:0] {
    MODE_IDLE    = 2'd0,
    MODE_ENTER   = 2'd1,
    MODE_CONFIRM = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_KEY   = 2'd1,
    CMD_TICK  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE     = 3'd0,
    ST_ENTERING = 3'd1,
    ST_PROMPT   = 3'd2,
    ST_RETRY    = 3'd3,
    ST_ACCEPT   = 3'd4,
    ST_CANCEL   = 3'd5,
    ST_TIMEOUT  = 3'd6,
    ST_MAXATT   = 3'd7
  } status_e;

  typedef enum logic {
    REG_TIMEOUT = 1'b0,
    REG_RETRIES = 1'b1
  } reg_e;

  localparam logic [3:0] KeyLastDigit = 4'd9;
  localparam logic [3:0] KeyStar = 4'd10;
  localparam logic [3:0] KeyHash = 4'd11;

endpackage

`default_nettype wire

// File: hdl/keypad_id_entry_controller.sv
// Keypad ID entry controller, top level and only module.
// Depends on kpid_pkg for codes, widths and the ID length.
//
// The controller takes one transaction per clock on its input stream and
// returns exactly one result transaction for each. tuser carries the command
// (start a session, key pressed, one-second tick) and tdata the key code. All
// the work for an item is done in the cycle it is accepted: the session state
// (mode, digit buffer, digit count, attempt count and both timers) and the
// result register are updated at that same clock edge, so the next item sees
// the new state and can follow in the very next cycle. The result is valid in the
// cycle after its input transaction; throughput is one item per clock,
// limited only by the single output register, which keeps taking new items
// while a result waits as long as the downstream side takes that result in
// the same cycle. The digit buffer stores, for every position, the decimal
// value of the digits up to and including it (saturated at 1023), so the ID
// is ready when hash is pressed and each key costs one multiply-by-ten step.
// The buffer has no reset: a position is always written before it is read.
// The configuration port is always ready; registers must only be written
// while no session item is in flight.
`default_nettype none

module keypad_id_entry_controller (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // Input stream.
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  // tdata: [3:0] key, [7:4] zero.
  input  wire logic [kpid_pkg::InDataW-1:0]  s_axis_tdata,
  // tuser: [1:0] cmd.
  input  wire logic [1:0]                    s_axis_tuser,
  // Result stream.
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // tdata: [2:0] status, [12:3] id_value, [14:13] digits_entered,
  //        [18:15] attempts_used, [23:19] zero.
  output logic [kpid_pkg::OutDataW-1:0]      m_axis_tdata,
  // Configuration write channel.
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic                          cfg_index_i,
  input  wire logic [7:0]                    cfg_data_i
);

  import kpid_pkg::*;

  // Configuration registers.
  logic [TimeoutW-1:0] timeout_q;
  logic [RetryW-1:0]   retries_q;

  // Session state.
  mode_e               mode_q, mode_d;
  logic [DcntW-1:0]    dcnt_q, dcnt_d;
  logic [RetryW-1:0]   att_q, att_d;
  logic [TimeoutW-1:0] stimer_q, stimer_d;
  logic [TimeoutW-1:0] ctimer_q, ctimer_d;
  logic [IdW-1:0]      prefix_q [IdDigits];

  // Result register.
  logic                out_valid_q;
  logic [OutDataW-1:0] out_data_q, out_data_d;

  logic       in_acc;
  cmd_e       cmd;
  logic [3:0] key;
  status_e    status_d;
  logic [IdW-1:0] id_d;
  logic       wr_digit;
  logic [IdW-1:0] base;
  logic [IdW+3:0] grown;
  logic [IdW-1:0] next_prefix;
  logic [1:0] shown;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign cmd           = cmd_e'(s_axis_tuser);
  assign key           = s_axis_tdata[3:0];
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // Value of the buffer after appending the incoming digit.
  always_comb begin
    base = '0;
    if (dcnt_q != '0) begin
      base = prefix_q[IdxW'(dcnt_q - DcntW'(1))];
    end
    grown = ({4'b0, base} << 3) + ({4'b0, base} << 1) + {{IdW{1'b0}}, key};
    next_prefix = (grown > {4'b0, IdMax}) ? IdMax : grown[IdW-1:0];
  end

  function automatic status_e mode_status(mode_e m);
    status_e s;
    s = ST_IDLE;
    if (m == MODE_ENTER) begin
      s = ST_ENTERING;
    end else if (m == MODE_CONFIRM) begin
      s = ST_PROMPT;
    end
    return s;
  endfunction

  function automatic logic [TimeoutW-1:0] bump(logic [TimeoutW-1:0] t);
    return (t == '1) ? t : t + TimeoutW'(1);
  endfunction

  // Next session state and the result of the incoming item.
  always_comb begin
    mode_d   = mode_q;
    dcnt_d   = dcnt_q;
    att_d    = att_q;
    stimer_d = stimer_q;
    ctimer_d = ctimer_q;
    status_d = mode_status(mode_q);
    id_d     = '0;
    wr_digit = 1'b0;
    case (cmd)
      CMD_START: begin
        mode_d   = MODE_ENTER;
        dcnt_d   = '0;
        att_d    = '0;
        stimer_d = '0;
        ctimer_d = '0;
        status_d = ST_ENTERING;
      end
      CMD_KEY: begin
        if (key <= KeyHash) begin
          if (mode_q == MODE_ENTER) begin
            if (stimer_q >= timeout_q) begin
              mode_d   = MODE_IDLE;
              status_d = ST_TIMEOUT;
            end else if (key <= KeyLastDigit) begin
              if (dcnt_q < DcntW'(IdDigits)) begin
                wr_digit = 1'b1;
                dcnt_d   = dcnt_q + DcntW'(1);
              end
              status_d = ST_ENTERING;
            end else if (key == KeyStar) begin
              if (dcnt_q != '0) begin
                dcnt_d   = dcnt_q - DcntW'(1);
                status_d = ST_ENTERING;
              end else begin
                mode_d   = MODE_CONFIRM;
                ctimer_d = '0;
                status_d = ST_PROMPT;
              end
            end else begin
              // Hash: accept a full buffer, otherwise count a failed try.
              if (dcnt_q == DcntW'(IdDigits)) begin
                id_d     = prefix_q[IdxW'(IdDigits - 1)];
                mode_d   = MODE_IDLE;
                status_d = ST_ACCEPT;
              end else begin
                if (att_q != '1) begin
                  att_d = att_q + RetryW'(1);
                end
                if (att_d >= retries_q) begin
                  mode_d   = MODE_IDLE;
                  status_d = ST_MAXATT;
                end else begin
                  dcnt_d   = '0;
                  status_d = ST_RETRY;
                end
              end
            end
          end else if (mode_q == MODE_CONFIRM) begin
            if (ctimer_q >= timeout_q) begin
              mode_d   = MODE_IDLE;
              status_d = ST_TIMEOUT;
            end else if (key == KeyStar) begin
              mode_d   = MODE_IDLE;
              status_d = ST_CANCEL;
            end else if (key == KeyHash) begin
              // Back to entry, unless the session time ran out meanwhile.
              if (stimer_q >= timeout_q) begin
                mode_d   = MODE_IDLE;
                status_d = ST_TIMEOUT;
              end else begin
                mode_d   = MODE_ENTER;
                status_d = ST_ENTERING;
              end
            end else begin
              status_d = ST_PROMPT;
            end
          end
        end
      end
      CMD_TICK: begin
        if (mode_q == MODE_ENTER) begin
          stimer_d = bump(stimer_q);
          if (stimer_d >= timeout_q) begin
            mode_d   = MODE_IDLE;
            status_d = ST_TIMEOUT;
          end
        end else if (mode_q == MODE_CONFIRM) begin
          stimer_d = bump(stimer_q);
          ctimer_d = bump(ctimer_q);
          if (ctimer_d >= timeout_q) begin
            mode_d   = MODE_IDLE;
            status_d = ST_TIMEOUT;
          end
        end
      end
      default: begin
        status_d = mode_status(mode_q);
      end
    endcase

    shown = (32'(dcnt_d) > 32'd3) ? 2'd3 : 2'(dcnt_d);
    out_data_d = {5'b0, att_d, shown, id_d, status_d};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TimeoutReset;
      retries_q <= RetryReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (reg_e'(cfg_index_i))
        REG_TIMEOUT: timeout_q <= cfg_data_i;
        REG_RETRIES: retries_q <= cfg_data_i[RetryW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_IDLE;
      dcnt_q   <= '0;
      att_q    <= '0;
      stimer_q <= '0;
      ctimer_q <= '0;
    end else if (in_acc) begin
      mode_q   <= mode_d;
      dcnt_q   <= dcnt_d;
      att_q    <= att_d;
      stimer_q <= stimer_d;
      ctimer_q <= ctimer_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && wr_digit) begin
      prefix_q[IdxW'(dcnt_q)] <= next_prefix;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      out_data_q <= out_data_d;
    end
  end

  // A result that ends the session leaves the controller idle.
  a_end_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (status_d == ST_ACCEPT || status_d == ST_CANCEL ||
               status_d == ST_TIMEOUT || status_d == ST_MAXATT)
    |=> mode_q == MODE_IDLE)
    else $error("session end did not return to idle");

  // A start yields an entering result with cleared counts.
  a_start_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && cmd == CMD_START
    |=> m_axis_tvalid && m_axis_tdata[2:0] == ST_ENTERING &&
        m_axis_tdata[18:13] == 6'd0)
    else $error("start did not clear the session");

  // The digit count never exceeds the buffer length.
  a_dcnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dcnt_q <= DcntW'(IdDigits))
    else $error("digit count beyond buffer length");

  // An empty output register never blocks the input side.
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> s_axis_tready)
    else $error("input stalled with empty result register");

  // Accepted IDs come only from a full buffer.
  a_accept_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && status_d == ST_ACCEPT |-> dcnt_q == DcntW'(IdDigits))
    else $error("ID accepted from a short buffer");

endmodule

`default_nettype wire
